// ===== rtl/cis_pkg.sv =====
// cis_pkg: shared types and constants for the instruction cluster steering block
// holds the input and result word structs, policy codes, register indexes
// no dependencies
package cis_pkg;

	localparam int SRC_SLOTS        = 3;
	localparam int DST_SLOTS        = 2;
	localparam int HINT_ENTRIES_DEF = 32;
	localparam int CNT_W            = 32;
	localparam int REG_W            = 10;
	localparam int CFG_W            = 8;
	localparam int CFG_IDX_W        = 2;

	localparam logic [2:0] POL_MODN   = 3'd0;
	localparam logic [2:0] POL_RR     = 3'd1;
	localparam logic [2:0] POL_PC     = 3'd2;
	localparam logic [2:0] POL_PROD   = 3'd3;
	localparam logic [2:0] POL_PARITY = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROUP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PCBIT  = 2'd2;

	localparam logic [7:0] GROUP_RST = 8'd1;
	localparam logic [5:0] PCBIT_RST = 6'd2;

	typedef struct packed {
		logic [63:0]      pc;
		logic [REG_W-1:0] src_reg_0;
		logic [REG_W-1:0] src_reg_1;
		logic [REG_W-1:0] src_reg_2;
		logic [REG_W-1:0] dst_reg_0;
		logic [REG_W-1:0] dst_reg_1;
	} in_word_t;

	typedef struct packed {
		logic       cluster;
		logic [1:0] cluster_mask;
	} out_word_t;

endpackage

// ===== rtl/instruction_cluster_steering.sv =====
// instruction_cluster_steering: steers each instruction word to one of two clusters
// contains the sequencer, the shared radix-2 divider and the hint memory
// depends on cis_pkg
//
// One input word yields one result word. The sequencer works on one word at a time:
// the mod-N step runs a radix-2 divider over the 32-bit steer counter, one quotient bit
// per cycle; the producer-locality policy first reads the hint memory once per source,
// each read taking an ST_RD and then an ST_ACC state; the other policies go straight
// from idle to the pick. Hints are kept in one single-port memory for int and float
// registers with a valid bit per entry, so reset leaves every hint unknown at once.
// A finished result waits in the output register while the next word is accepted.
module instruction_cluster_steering
	import cis_pkg::*;
#(
	parameter int HINT_ENTRIES = HINT_ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W     = (HINT_ENTRIES > 1) ? $clog2(HINT_ENTRIES) : 1;
	localparam int MEM_DEPTH = 2 << IDX_W;
	localparam int ADDR_W    = IDX_W + 1;
	localparam int SSEL_W    = (SRC_SLOTS > 1) ? $clog2(SRC_SLOTS) : 1;
	localparam int DSEL_W    = (DST_SLOTS > 1) ? $clog2(DST_SLOTS) : 1;
	localparam int SLOT_W    = (SSEL_W > DSEL_W) ? SSEL_W : DSEL_W;
	localparam int VOTE_W    = $clog2(SRC_SLOTS + 1);
	localparam int DCNT_W    = $clog2(CNT_W);
	localparam logic [8:0] HINT_LIM = 9'(HINT_ENTRIES);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_ACC  = 7'b0000100,
		ST_PICK = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_WR   = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [2:0]        policy_q;
	logic [7:0]        group_q;
	logic [5:0]        pc_bit_q;
	logic [CNT_W-1:0]  counter_q;
	logic [63:0]       pc_q;
	logic [REG_W-1:0]  src_q [SRC_SLOTS];
	logic [REG_W-1:0]  dst_q [DST_SLOTS];
	logic [SLOT_W-1:0] slot_q;
	logic [VOTE_W-1:0] v0_q;
	logic [VOTE_W-1:0] v1_q;
	logic              cl_q;
	logic [CNT_W-1:0]  dvd_q;
	logic [7:0]        rem_q;
	logic [7:0]        div_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic              hint_mem_q [MEM_DEPTH];
	logic              hint_vld_q [MEM_DEPTH];
	logic              rd_bit_q;
	logic              rd_vld_q;
	logic              rd_ok_q;

	logic [REG_W-1:0]  rd_reg;
	logic [REG_W-1:0]  wr_reg;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_ok;
	logic              wr_en;
	logic              par_found;
	logic              par_cl;
	logic              pick_div;
	logic              pick_cl;
	logic [8:0]        div_r;
	logic              div_ge;
	logic [8:0]        div_diff;
	logic              out_load;

	function automatic logic hint_ok(input logic [REG_W-1:0] r);
		hint_ok = !r[9] && ({1'b0, r[7:0]} < HINT_LIM);
	endfunction

	function automatic logic [ADDR_W-1:0] hint_addr(input logic [REG_W-1:0] r);
		hint_addr = {r[8], r[IDX_W-1:0]};
	endfunction

	// hint memory ports
	always_comb begin
		rd_reg  = src_q[slot_q[SSEL_W-1:0]];
		wr_reg  = dst_q[slot_q[DSEL_W-1:0]];
		rd_addr = hint_addr(rd_reg);
		wr_addr = hint_addr(wr_reg);
		rd_ok   = hint_ok(rd_reg);
		wr_en   = (state_q == ST_WR) && hint_ok(wr_reg);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hint_mem_q[wr_addr] <= cl_q;
		end else begin
			rd_bit_q <= hint_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MEM_DEPTH; i++) begin
				hint_vld_q[i] <= 1'b0;
			end
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				hint_vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= hint_vld_q[rd_addr];
		end
	end

	// first int or float register, destinations before sources
	always_comb begin
		par_found = 1'b0;
		par_cl    = 1'b0;
		for (int i = SRC_SLOTS - 1; i >= 0; i--) begin
			if (!src_q[i][9]) begin
				par_found = 1'b1;
				par_cl    = src_q[i][0];
			end
		end
		for (int i = DST_SLOTS - 1; i >= 0; i--) begin
			if (!dst_q[i][9]) begin
				par_found = 1'b1;
				par_cl    = dst_q[i][0];
			end
		end
	end

	always_comb begin
		pick_div = 1'b0;
		pick_cl  = 1'b0;
		unique case (policy_q)
			POL_MODN: begin
				pick_div = 1'b1;
			end
			POL_RR: begin
				pick_cl = counter_q[0];
			end
			POL_PC: begin
				pick_cl = pc_q[pc_bit_q];
			end
			POL_PROD: begin
				if (v0_q > v1_q) begin
					pick_cl = 1'b0;
				end else if (v1_q > v0_q) begin
					pick_cl = 1'b1;
				end else if (par_found) begin
					pick_cl = par_cl;
				end else begin
					pick_div = 1'b1;
				end
			end
			default: begin
				if (par_found) begin
					pick_cl = par_cl;
				end else begin
					pick_div = 1'b1;
				end
			end
		endcase
	end

	// restoring divider step
	always_comb begin
		div_r    = {rem_q, dvd_q[CNT_W-1]};
		div_ge   = div_r >= {1'b0, div_q};
		div_diff = div_r - {1'b0, div_q};
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_PARITY;
			group_q  <= GROUP_RST;
			pc_bit_q <= PCBIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_POLICY: policy_q <= cfg_data[2:0];
				CFG_GROUP:  group_q  <= cfg_data;
				CFG_PCBIT:  pc_bit_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			counter_q   <= '0;
			slot_q      <= '0;
			v0_q        <= '0;
			v1_q        <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						slot_q  <= '0;
						v0_q    <= '0;
						v1_q    <= '0;
						state_q <= (policy_q == POL_PROD) ? ST_RD : ST_PICK;
					end
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (rd_ok_q && rd_vld_q) begin
						if (rd_bit_q) begin
							v1_q <= v1_q + 1'b1;
						end else begin
							v0_q <= v0_q + 1'b1;
						end
					end
					if (slot_q == SLOT_W'(SRC_SLOTS - 1)) begin
						state_q <= ST_PICK;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_PICK: begin
					slot_q <= '0;
					dcnt_q <= '0;
					if (pick_div || policy_q == POL_RR) begin
						counter_q <= counter_q + 1'b1;
					end
					state_q <= pick_div ? ST_DIV : ST_WR;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(CNT_W - 1)) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (slot_q == SLOT_W'(DST_SLOTS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pc_q     <= in_word.pc;
			src_q[0] <= in_word.src_reg_0;
			src_q[1] <= in_word.src_reg_1;
			src_q[2] <= in_word.src_reg_2;
			dst_q[0] <= in_word.dst_reg_0;
			dst_q[1] <= in_word.dst_reg_1;
		end
		if (state_q == ST_RD) begin
			rd_ok_q <= rd_ok;
		end
		if (state_q == ST_PICK) begin
			cl_q  <= pick_cl;
			dvd_q <= counter_q;
			rem_q <= '0;
			div_q <= (group_q == '0) ? 8'd1 : group_q;
		end
		if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
			rem_q <= div_ge ? div_diff[7:0] : div_r[7:0];
			cl_q  <= div_ge;
		end
		if (out_load) begin
			out_word_q.cluster      <= cl_q;
			out_word_q.cluster_mask <= {cl_q, ~cl_q};
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef SYNTHESIS
	a_mask_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.cluster_mask == {out_word.cluster, ~out_word.cluster})
		else $error("cluster mask does not match cluster");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q != $past(counter_q) |-> counter_q == $past(counter_q) + 1'b1)
		else $error("steer counter moved by more than one");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside completion");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != ST_IDLE)
		else $error("accepted word did not start the sequencer");

	a_div_only_when_needed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PICK && !pick_div && policy_q != POL_RR |=> $stable(counter_q))
		else $error("steer counter advanced without a mod-N or round robin step");
`endif

endmodule
